// ===== design/psvb_pkg.sv =====
// shared types, constants and table functions for the sine voice bank
package psvb_pkg;

  // voice bank shape
  localparam int VOICE_COUNT      = 128;
  localparam int PHASE_BITS       = 24;
  localparam int TIMER_BITS       = 24;
  localparam int SINE_TABLE_DEPTH = 256;
  localparam int VIDX_BITS        = $clog2(VOICE_COUNT);

  // port field widths
  localparam int CMD_BITS    = 2;
  localparam int NOTE_BITS   = 8;
  localparam int DUR_BITS    = 24;
  localparam int SAMPLE_BITS = 16;
  localparam int RATE_BITS   = 20;
  localparam logic [RATE_BITS-1:0] RATE_RESET = 20'd89478;

  // sine table
  localparam int AMPLITUDE  = 3000;
  localparam int AMP_BITS   = $clog2(AMPLITUDE + 1);
  localparam int SINE_BITS  = AMP_BITS + 1;
  localparam int SADDR_BITS = $clog2(SINE_TABLE_DEPTH);
  localparam int POS_BITS   = SADDR_BITS + 2;
  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // pitch: Q24 base frequency, rate is 2^32 over sample rate
  localparam int SEMITONES   = 12;
  localparam int SEMI_BITS   = $clog2(SEMITONES);
  localparam int OCT_MAX     = (VOICE_COUNT - 1) / SEMITONES;
  localparam int OCT_BITS    = $clog2(OCT_MAX + 1);
  localparam int BASE_BITS   = 28;
  localparam int FREQ_FRAC   = 24;
  localparam int RATE_FRAC   = 32;
  localparam int PROD_BITS   = BASE_BITS + RATE_BITS;
  localparam int STEP_SHIFT  = FREQ_FRAC + RATE_FRAC - PHASE_BITS;
  localparam int SHIFT_BITS  = PROD_BITS + OCT_MAX;
  localparam int STEP_BITS   = SHIFT_BITS - STEP_SHIFT;

  // mix accumulator wide enough for every voice at full amplitude
  localparam int SUM_BITS = $clog2(VOICE_COUNT * AMPLITUDE + (1 << (SAMPLE_BITS - 1))) + 1;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_RENDER   = 2'd0,
    CMD_ON_HELD  = 2'd1,
    CMD_ON_TIMED = 2'd2,
    CMD_OFF      = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_IDLE      = 2'd0,
    MODE_HELD      = 2'd1,
    MODE_TIMED     = 2'd2,
    MODE_RELEASING = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t                  mode;
    logic [PHASE_BITS-1:0]  phase;
    logic [TIMER_BITS-1:0]  timer;
  } voice_t;

  typedef struct packed {
    logic                  en;
    logic [VIDX_BITS-1:0]  addr;
    voice_t                data;
  } voice_wr_t;

  // base frequencies of the lowest octave, Q24
  function automatic logic [BASE_BITS-1:0] octave_base(input logic [SEMI_BITS-1:0] semi);
    logic [BASE_BITS-1:0] b;
    unique case (semi)
      4'd0:    b = 28'd137167144;
      4'd1:    b = 28'd145323527;
      4'd2:    b = 28'd153964914;
      4'd3:    b = 28'd163120144;
      4'd4:    b = 28'd172819773;
      4'd5:    b = 28'd183096171;
      4'd6:    b = 28'd193983636;
      4'd7:    b = 28'd205518503;
      4'd8:    b = 28'd217739269;
      4'd9:    b = 28'd230686720;
      4'd10:   b = 28'd244404066;
      4'd11:   b = 28'd258937088;
      default: b = '0;
    endcase
    return b;
  endfunction

  // quarter-wave entry k, Taylor sine in Q30, evaluated at elaboration
  function automatic logic [AMP_BITS-1:0] qsine_val(input int unsigned k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] r;
    x  = (HALF_PI_Q30 * 64'(k)) / SINE_TABLE_DEPTH;
    x2 = (x * x) >> 30;
    t  = Q30_ONE - x2 / 64'd110;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
    s  = (x * t) >> 30;
    r  = (64'(AMPLITUDE) * s + (Q30_ONE >> 1)) >> 30;
    return r[AMP_BITS-1:0];
  endfunction

endpackage

// ===== design/psvb_voice_mem.sv =====
// voice state memory with per-entry valid bits, registered read
module psvb_voice_mem
  import psvb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [VIDX_BITS-1:0] rd_addr,
  input  voice_wr_t            wr,
  output voice_t               rd_data
);

  voice_t                 voice_ram_r [VOICE_COUNT];
  logic [VOICE_COUNT-1:0] valid_r;
  voice_t                 rd_q_r;
  logic                   rd_vld_r;

  // storage array
  always_ff @(posedge clk) begin
    if (wr.en) begin
      voice_ram_r[wr.addr] <= wr.data;
    end
    rd_q_r <= voice_ram_r[rd_addr];
  end

  // valid bits, an unwritten entry reads as an idle voice
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= valid_r[rd_addr];
      if (wr.en) begin
        valid_r[wr.addr] <= 1'b1;
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule

// ===== design/psvb_sine_lookup.sv =====
// quarter-wave sine lookup from phase, mirrored and negated per quadrant
module psvb_sine_lookup
  import psvb_pkg::*;
(
  input  logic [PHASE_BITS-1:0]       phase,
  output logic signed [SINE_BITS-1:0] sine
);

  localparam logic [AMP_BITS-1:0] PEAK = qsine_val(SINE_TABLE_DEPTH);

  logic [AMP_BITS-1:0]   rom [SINE_TABLE_DEPTH];
  logic [POS_BITS-1:0]   pos;
  logic [1:0]            quad;
  logic [SADDR_BITS-1:0] idx;
  logic [SADDR_BITS-1:0] addr;
  logic [AMP_BITS-1:0]   mag;
  logic [SINE_BITS-1:0]  mag_ext;

  // constant table
  for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_rom
    assign rom[k] = qsine_val(k);
  end

  // top phase bits pick quadrant and table index
  assign pos  = phase[PHASE_BITS-1 -: POS_BITS];
  assign quad = pos[POS_BITS-1 -: 2];
  assign idx  = pos[SADDR_BITS-1:0];
  assign addr = quad[0] ? (~idx + 1'b1) : idx;

  // mirrored quadrant at index zero lands on the peak entry
  always_comb begin
    if (quad[0] && (idx == '0)) begin
      mag = PEAK;
    end else begin
      mag = rom[addr];
    end
    mag_ext = {1'b0, mag};
    sine    = quad[1] ? -signed'(mag_ext) : signed'(mag_ext);
  end

endmodule

// ===== design/psvb_pitch_step.sv =====
// per-note phase step: base times rate, registered, then octave shift
module psvb_pitch_step
  import psvb_pkg::*;
(
  input  logic                 clk,
  input  logic [SEMI_BITS-1:0] semi,
  input  logic [OCT_BITS-1:0]  oct,
  input  logic [RATE_BITS-1:0] rate_scale,
  output logic [STEP_BITS-1:0] step
);

  logic [PROD_BITS-1:0]  prod_r;
  logic [OCT_BITS-1:0]   oct_r;
  logic [SHIFT_BITS-1:0] shifted;

  // multiply stage
  always_ff @(posedge clk) begin
    prod_r <= PROD_BITS'(octave_base(semi)) * PROD_BITS'(rate_scale);
    oct_r  <= oct;
  end

  // octave shift and drop of the fraction
  assign shifted = SHIFT_BITS'(prod_r) << oct_r;
  assign step    = shifted[SHIFT_BITS-1 -: STEP_BITS];

endmodule

// ===== design/polyphonic_sine_voice_bank_top.sv =====
// polyphonic sine voice bank: sequencer, voice update pipeline and mixer
//
// Input channel (in_valid / in_stall) takes one command word: render one
// sample, note on held, note on timed, or note off. A note command is a
// read-modify-write of one voice entry; notes at or above the voice count
// are dropped in the accept cycle. A render walks all 128 voices through
// one shared update unit, one voice per cycle, in a short pipeline (memory
// read and pitch multiply, voice update and sine lookup, accumulate), so
// its result word is loaded once the pipeline has drained, and the next
// command is taken once that result word has been loaded.
// in_stall is high while a command is in progress and during reset.
// Result channel (out_valid / out_stall) carries one word per render: the
// 16-bit saturated mix and a clipped flag. The result sits in an output
// register; a new command is accepted while it waits, and a following render
// holds in its last step until the earlier word has been taken.
// cfg_wr_en writes rate_scale; write it only while the block is idle.
// Reset (rst_n low, synchronous) marks every voice idle with zero phase and
// timer and restores the default rate_scale.
module polyphonic_sine_voice_bank_top
  import psvb_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [RATE_BITS-1:0]          cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [CMD_BITS-1:0]           in_cmd,
  input  logic [NOTE_BITS-1:0]          in_note,
  input  logic [DUR_BITS-1:0]           in_duration,
  input  logic signed [SAMPLE_BITS-1:0] in_mix_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_sample,
  output logic                          out_clipped
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NOTE,
    ST_RUN,
    ST_FLUSH,
    ST_DONE
  } state_t;

  localparam logic signed [SUM_BITS-1:0] SAT_HI = SUM_BITS'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [SUM_BITS-1:0] SAT_LO = -SUM_BITS'(1 << (SAMPLE_BITS - 1));
  localparam logic [VIDX_BITS-1:0]       LAST_VOICE = VIDX_BITS'(VOICE_COUNT - 1);

  state_t                      state_r;
  logic [RATE_BITS-1:0]        rate_scale_r;
  cmd_t                        cmd_r;
  logic [VIDX_BITS-1:0]        note_r;
  logic [TIMER_BITS-1:0]       dur_r;
  logic [VIDX_BITS-1:0]        vidx_r;
  logic [SEMI_BITS-1:0]        semi_r;
  logic [OCT_BITS-1:0]         oct_r;
  logic                        s1_vld_r;
  logic [VIDX_BITS-1:0]        s1_idx_r;
  logic                        s2_vld_r;
  logic signed [SINE_BITS-1:0] s2_sine_r;
  logic signed [SUM_BITS-1:0]  acc_r;
  logic                        out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_sample_r;
  logic                        out_clipped_r;

  logic                        in_acc;
  logic [VIDX_BITS-1:0]        rd_addr;
  voice_t                      rd_data;
  voice_wr_t                   wr;
  logic [STEP_BITS-1:0]        step;
  logic signed [SINE_BITS-1:0] sine;
  voice_t                      note_upd;
  voice_t                      voice_upd;
  logic                        voice_act;
  logic [TIMER_BITS-1:0]       timer_dec;
  mode_t                       mode_tmp;
  logic [STEP_BITS:0]          phase_sum;
  logic                        wrap;
  logic signed [SAMPLE_BITS-1:0] sat_sample;
  logic                        sat_clip;

  assign in_stall = (state_r != ST_IDLE) || !rst_n;
  assign in_acc   = in_valid && !in_stall;

  // voice memory is read at the incoming note or at the walking voice index
  assign rd_addr = (state_r == ST_RUN) ? vidx_r : in_note[VIDX_BITS-1:0];

  psvb_voice_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (rd_addr),
    .wr      (wr),
    .rd_data (rd_data)
  );

  psvb_pitch_step u_pitch (
    .clk        (clk),
    .semi       (semi_r),
    .oct        (oct_r),
    .rate_scale (rate_scale_r),
    .step       (step)
  );

  psvb_sine_lookup u_sine (
    .phase (rd_data.phase),
    .sine  (sine)
  );

  // note command update of one voice entry
  always_comb begin
    note_upd = rd_data;
    unique case (cmd_r)
      CMD_ON_HELD: begin
        note_upd.mode = MODE_HELD;
      end
      CMD_ON_TIMED: begin
        note_upd.timer = dur_r;
        note_upd.mode  = (dur_r != '0) ? MODE_TIMED : MODE_IDLE;
      end
      CMD_OFF: begin
        if ((rd_data.mode == MODE_HELD) || (rd_data.mode == MODE_TIMED)) begin
          note_upd.mode = MODE_RELEASING;
        end else begin
          note_upd.mode = MODE_IDLE;
        end
      end
      default: begin
        note_upd = rd_data;
      end
    endcase
  end

  // render update of one voice: timer, phase advance, wrap and release
  always_comb begin
    voice_act = (rd_data.mode != MODE_IDLE);
    timer_dec = rd_data.timer;
    mode_tmp  = rd_data.mode;
    if (rd_data.mode == MODE_TIMED) begin
      if (rd_data.timer != '0) begin
        timer_dec = rd_data.timer - 1'b1;
      end
      if (timer_dec == '0) begin
        mode_tmp = MODE_RELEASING;
      end
    end
    phase_sum = (STEP_BITS + 1)'(rd_data.phase) + (STEP_BITS + 1)'(step);
    wrap      = |phase_sum[STEP_BITS:PHASE_BITS];
    voice_upd = rd_data;
    if (voice_act) begin
      voice_upd.timer = timer_dec;
      voice_upd.mode  = mode_tmp;
      if (wrap) begin
        voice_upd.phase = '0;
        if (mode_tmp == MODE_RELEASING) begin
          voice_upd.mode = MODE_IDLE;
        end
      end else begin
        voice_upd.phase = phase_sum[PHASE_BITS-1:0];
      end
    end
  end

  // write port: note entry or the voice leaving the update stage
  always_comb begin
    wr.en   = 1'b0;
    wr.addr = s1_idx_r;
    wr.data = voice_upd;
    if (state_r == ST_NOTE) begin
      wr.en   = 1'b1;
      wr.addr = note_r;
      wr.data = note_upd;
    end else if (s1_vld_r) begin
      wr.en = 1'b1;
    end
  end

  // saturation of the finished mix
  always_comb begin
    sat_clip   = 1'b0;
    sat_sample = acc_r[SAMPLE_BITS-1:0];
    if (acc_r > SAT_HI) begin
      sat_clip   = 1'b1;
      sat_sample = SAT_HI[SAMPLE_BITS-1:0];
    end else if (acc_r < SAT_LO) begin
      sat_clip   = 1'b1;
      sat_sample = SAT_LO[SAMPLE_BITS-1:0];
    end
  end

  // rate register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_scale_r <= RATE_RESET;
    end else if (cfg_wr_en) begin
      rate_scale_r <= cfg_wr_data;
    end
  end

  // pipeline data registers and mix accumulator
  always_ff @(posedge clk) begin
    s1_idx_r  <= vidx_r;
    s2_sine_r <= voice_act ? sine : '0;
    if (in_acc) begin
      cmd_r  <= cmd_t'(in_cmd);
      note_r <= in_note[VIDX_BITS-1:0];
      dur_r  <= in_duration[TIMER_BITS-1:0];
      acc_r  <= {{(SUM_BITS - SAMPLE_BITS){in_mix_in[SAMPLE_BITS-1]}}, in_mix_in};
    end else if (s2_vld_r) begin
      acc_r <= acc_r + SUM_BITS'(s2_sine_r);
    end
  end

  // sequencer, stage valids and result word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      vidx_r      <= '0;
      semi_r      <= '0;
      oct_r       <= '0;
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_vld_r <= (state_r == ST_RUN);
      s2_vld_r <= s1_vld_r && (state_r != ST_NOTE);
      if (out_valid_r && !out_stall && (state_r != ST_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          vidx_r <= '0;
          semi_r <= '0;
          oct_r  <= '0;
          if (in_acc) begin
            if (cmd_t'(in_cmd) == CMD_RENDER) begin
              state_r <= ST_RUN;
            end else if (in_note < NOTE_BITS'(VOICE_COUNT)) begin
              state_r <= ST_NOTE;
            end
          end
        end
        ST_NOTE: begin
          state_r <= ST_IDLE;
        end
        ST_RUN: begin
          vidx_r <= vidx_r + 1'b1;
          if (semi_r == SEMI_BITS'(SEMITONES - 1)) begin
            semi_r <= '0;
            oct_r  <= oct_r + 1'b1;
          end else begin
            semi_r <= semi_r + 1'b1;
          end
          if (vidx_r == LAST_VOICE) begin
            state_r <= ST_FLUSH;
          end
        end
        ST_FLUSH: begin
          if (!s1_vld_r && !s2_vld_r) begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r   <= 1'b1;
            out_sample_r  <= sat_sample;
            out_clipped_r <= sat_clip;
            state_r       <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid   = out_valid_r;
  assign out_sample  = out_sample_r;
  assign out_clipped = out_clipped_r;

endmodule
